// ===== hdl/tct_pkg.sv =====
// Shared widths, types and constants for the triangle tangent block.
// Depends on nothing; every other file of the block imports it.
package tct_pkg;

	localparam int POS_W     = 24;              // position, Q12.12
	localparam int TEX_W     = 16;              // texture coordinate, Q4.12
	localparam int OUT_W     = 16;              // tangent component, Q1.14
	localparam int DT_W      = TEX_W + 1;       // texcoord difference
	localparam int DP_W      = POS_W + 1;       // position difference
	localparam int MUL_W     = 31;              // shared multiplier operand
	localparam int PROD_W    = 2 * MUL_W;       // shared multiplier product
	localparam int MAG_W     = 43;              // unnormalized component magnitude
	localparam int NRM_W     = 30;              // largest normalized magnitude lies in [2^29, 2^30)
	localparam int SUM_W     = 62;              // sum of three squares
	localparam int ROOT_W    = SUM_W / 2;       // vector length
	localparam int QUO_W     = 16;              // quotient bits of the divider
	localparam int FRAC_W    = 14;              // fraction bits of the output
	localparam int NUM_W     = NRM_W + FRAC_W + 1;
	localparam int ONE_Q14   = 1 << FRAC_W;
	localparam int ROT_COUNT = 3;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [TEX_W-1:0] tex_t;
	typedef logic signed [OUT_W-1:0] tan_t;
	typedef logic [MAG_W-1:0]        mag_t;

endpackage

// ===== hdl/tct_if.sv =====
// Valid/ready channel interfaces for vertex words in and tangent words out.
// Depends on tct_pkg.
interface tct_vtx_if import tct_pkg::*; ();
	logic valid;
	logic ready;
	pos_t pos_x;
	pos_t pos_y;
	pos_t pos_z;
	tex_t tex_u;
	tex_t tex_v;

	modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tct_tan_if import tct_pkg::*; ();
	logic valid;
	logic ready;
	tan_t tan_x;
	tan_t tan_y;
	tan_t tan_z;
	logic degenerate;
	logic last_of_triangle;

	modport source(output valid, tan_x, tan_y, tan_z, degenerate, last_of_triangle,
		input ready);
	modport sink(input valid, tan_x, tan_y, tan_z, degenerate, last_of_triangle,
		output ready);
endinterface

// ===== hdl/tct_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on tct_pkg.
module tct_isqrt import tct_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int STEPS = SUM_W / 2;

	logic             busy_q;
	logic             done_q;
	logic [4:0]       bitpos_q;
	logic [SUM_W-1:0] n_q;
	logic [SUM_W-1:0] r_q;
	logic [SUM_W-1:0] bitval;
	logic [SUM_W-1:0] trial;
	logic             ge;

	assign bitval = SUM_W'(1) << {bitpos_q, 1'b0};
	assign trial  = r_q + bitval;
	assign ge     = n_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			bitpos_q <= '0;
		end else if (start) begin
			busy_q   <= 1'b1;
			done_q   <= 1'b0;
			bitpos_q <= 5'(STEPS - 1);
		end else if (busy_q) begin
			if (bitpos_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				bitpos_q <= bitpos_q - 5'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			r_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				n_q <= n_q - trial;
				r_q <= (r_q >> 1) + bitval;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];

endmodule

// ===== hdl/tct_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient known to fit QUO_W bits.
// Depends on tct_pkg.
module tct_div import tct_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  numer,
	input  logic [ROOT_W-1:0] denom,
	output logic              done,
	output logic [QUO_W-1:0]  quot
);

	logic              busy_q;
	logic              done_q;
	logic [3:0]        cnt_q;
	logic [ROOT_W:0]   rem_q;
	logic [QUO_W-1:0]  low_q;
	logic [QUO_W-1:0]  quot_q;
	logic [ROOT_W:0]   sh;
	logic              ge;

	assign sh = {rem_q[ROOT_W-1:0], low_q[QUO_W-1]};
	assign ge = sh >= {1'b0, denom};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 4'(QUO_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= (ROOT_W+1)'(numer >> QUO_W);
			low_q  <= numer[QUO_W-1:0];
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? sh - {1'b0, denom} : sh;
			low_q  <= low_q << 1;
			quot_q <= {quot_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== hdl/triangle_tangent_calc.sv =====
// Top level of the per-vertex tangent unit: sequencer, shared multiplier, output register.
// Depends on tct_pkg, tct_if, tct_isqrt and tct_div.
//
//  channel | dir | word                                          | handshake
//  vtx     | in  | pos_x, pos_y, pos_z, tex_u, tex_v             | valid/ready
//  tan     | out | tan_x, tan_y, tan_z, degenerate, last_of_tri. | valid/ready
//
// The first two vertices of a triangle are held while the sequencer stays idle.
// The third starts three rotations; each non-degenerate one runs the bit-serial square root
// (31 steps) and three 16-step divisions on the shared units, plus the
// normalization shifts. vtx.ready is high only while the sequencer is idle.
// A waiting tangent word stalls the sequencer before it loads the next one.
// arst_n clears the vertex phase.
module triangle_tangent_calc import tct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	tct_vtx_if.sink  vtx,
	tct_tan_if.source tan
);

	typedef enum logic [2:0] {
		S_IDLE, S_DIFF, S_MUL, S_NORM, S_SQ, S_ROOT, S_DIV, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] phase_q;
	logic [1:0] ph_eff;
	logic [1:0] rot_q;
	logic [3:0] cnt_q;
	logic       sqrt_start_q;
	logic       div_start_q;
	logic       tan_valid_q;
	logic       deg_q;

	// held vertices; slot 0 is the corner of the current rotation
	pos_t pos_q [3][3];
	tex_t tex_q [3][2];

	logic signed [DT_W-1:0] s1_q, t1_q, s2_q, t2_q;
	logic signed [DP_W-1:0] q1_q [3];
	logic signed [DP_W-1:0] q2_q [3];

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic signed [MAG_W-1:0]  diff, cval;
	logic                     det_neg_q, det_zero_q;
	logic [1:0]               pair, comp;
	mag_t                     mag_q [3];
	logic                     sgn_q [3];
	logic [SUM_W-1:0]         sum_q;
	logic [ROOT_W-1:0]        len_q;
	tan_t                     tanv_q [3];

	logic              sqrt_done, div_done;
	logic [ROOT_W-1:0] sqrt_root;
	logic [QUO_W-1:0]  div_quot;
	logic [NUM_W-1:0]  numer;
	logic              accept, out_free, load_out, big, tiny, all_zero;
	tan_t              qsig;

	assign accept   = vtx.valid && vtx.ready;
	assign vtx.ready = (state_q == S_IDLE);
	assign out_free = !tan_valid_q || tan.ready;
	assign load_out = (state_q == S_OUT) && out_free;
	assign ph_eff   = (phase_q == 2'd3) ? 2'd0 : phase_q;
	assign pair     = cnt_q[3:2];
	assign comp     = pair - 2'd1;

	// shared multiplier operands: cross products, then squares
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_SQ) begin
			mul_a = MUL_W'(mag_q[cnt_q[2:1]][NRM_W-1:0]);
			mul_b = mul_a;
		end else begin
			mul_b = cnt_q[1] ? MUL_W'(t1_q) : MUL_W'(t2_q);
			if (pair == 2'd0)
				mul_a = cnt_q[1] ? MUL_W'(s2_q) : MUL_W'(s1_q);
			else
				mul_a = cnt_q[1] ? MUL_W'(q2_q[comp]) : MUL_W'(q1_q[comp]);
		end
	end

	assign diff = MAG_W'(acc_q - prod_q);
	assign cval = det_neg_q ? -diff : diff;

	always_comb begin
		big      = 1'b0;
		tiny     = 1'b1;
		all_zero = 1'b1;
		for (int k = 0; k < 3; k++) begin
			big      = big | (|mag_q[k][MAG_W-1:NRM_W]);
			tiny     = tiny & ~(|mag_q[k][MAG_W-1:NRM_W-1]);
			all_zero = all_zero & (mag_q[k] == '0);
		end
	end

	assign numer = (NUM_W'(mag_q[cnt_q[1:0]][NRM_W-1:0]) << FRAC_W) + NUM_W'(len_q >> 1);
	assign qsig  = tan_t'(div_quot);

	tct_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_q),
		.radicand (sum_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	tct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.numer  (numer),
		.denom  (len_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= '0;
			rot_q        <= '0;
			cnt_q        <= '0;
			sqrt_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			tan_valid_q  <= 1'b0;
			deg_q        <= 1'b0;
		end else begin
			// kick the square root after the last square, the divider after the root
			// and after each component but the last
			sqrt_start_q <= (state_q == S_SQ) && (cnt_q == 4'd5);
			div_start_q  <= ((state_q == S_ROOT) && sqrt_done) ||
				((state_q == S_DIV) && div_done && (cnt_q[1:0] != 2'(ROT_COUNT - 1)));
			if (load_out)
				tan_valid_q <= 1'b1;
			else if (tan.ready)
				tan_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (ph_eff == 2'd2) begin
							phase_q <= '0;
							rot_q   <= '0;
							state_q <= S_DIFF;
						end else begin
							phase_q <= ph_eff + 2'd1;
						end
					end
				end
				S_DIFF: begin
					deg_q   <= 1'b0;
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						// determinant and vector are done: drop a zero determinant
						if (det_zero_q) begin
							deg_q   <= 1'b1;
							state_q <= S_OUT;
						end else begin
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					// all three magnitudes are in place here: drop a zero vector
					if (all_zero) begin
						deg_q   <= 1'b1;
						state_q <= S_OUT;
					end else if (!big && !tiny) begin
						cnt_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd5)
						state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sqrt_done) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (cnt_q[1:0] == 2'(ROT_COUNT - 1))
							state_q <= S_OUT;
						else
							cnt_q <= cnt_q + 4'd1;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (rot_q == 2'(ROT_COUNT - 1)) begin
							state_q <= S_IDLE;
						end else begin
							rot_q   <= rot_q + 2'd1;
							state_q <= S_DIFF;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && ph_eff != 2'd3) begin
			pos_q[ph_eff][0] <= vtx.pos_x;
			pos_q[ph_eff][1] <= vtx.pos_y;
			pos_q[ph_eff][2] <= vtx.pos_z;
			tex_q[ph_eff][0] <= vtx.tex_u;
			tex_q[ph_eff][1] <= vtx.tex_v;
		end
		if (state_q == S_DIFF) begin
			s1_q <= DT_W'(tex_q[1][0]) - DT_W'(tex_q[0][0]);
			t1_q <= DT_W'(tex_q[1][1]) - DT_W'(tex_q[0][1]);
			s2_q <= DT_W'(tex_q[2][0]) - DT_W'(tex_q[0][0]);
			t2_q <= DT_W'(tex_q[2][1]) - DT_W'(tex_q[0][1]);
			for (int k = 0; k < 3; k++) begin
				q1_q[k]   <= DP_W'(pos_q[1][k]) - DP_W'(pos_q[0][k]);
				q2_q[k]   <= DP_W'(pos_q[2][k]) - DP_W'(pos_q[0][k]);
				tanv_q[k] <= '0;
			end
		end
		if (state_q == S_MUL || state_q == S_SQ) begin
			if (!cnt_q[0])
				prod_q <= mul_a * mul_b;
		end
		if (state_q == S_MUL && cnt_q[0]) begin
			if (!cnt_q[1]) begin
				acc_q <= prod_q;
			end else if (pair == 2'd0) begin
				det_neg_q  <= diff < 0;
				det_zero_q <= diff == '0;
			end else begin
				sgn_q[comp] <= cval < 0;
				mag_q[comp] <= cval < 0 ? mag_t'(-cval) : mag_t'(cval);
			end
		end
		if (state_q == S_NORM) begin
			for (int k = 0; k < 3; k++) begin
				if (big)
					mag_q[k] <= mag_q[k] >> 1;
				else if (tiny)
					mag_q[k] <= mag_q[k] << 1;
			end
			sum_q <= '0;
		end
		if (state_q == S_SQ && cnt_q[0])
			sum_q <= sum_q + SUM_W'(prod_q);
		if (state_q == S_ROOT && sqrt_done)
			len_q <= sqrt_root;
		if (state_q == S_DIV && div_done)
			tanv_q[cnt_q[1:0]] <= sgn_q[cnt_q[1:0]] ? -qsig : qsig;
		if (load_out) begin
			tan.tan_x            <= tanv_q[0];
			tan.tan_y            <= tanv_q[1];
			tan.tan_z            <= tanv_q[2];
			tan.degenerate       <= deg_q;
			tan.last_of_triangle <= rot_q == 2'(ROT_COUNT - 1);
			// advance to the next rotation of the triangle
			for (int k = 0; k < 3; k++) begin
				pos_q[0][k] <= pos_q[1][k];
				pos_q[1][k] <= pos_q[2][k];
				pos_q[2][k] <= pos_q[0][k];
			end
			for (int k = 0; k < 2; k++) begin
				tex_q[0][k] <= tex_q[1][k];
				tex_q[1][k] <= tex_q[2][k];
				tex_q[2][k] <= tex_q[0][k];
			end
		end
	end

	assign tan.valid = tan_valid_q;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> len_q[ROOT_W-1:NRM_W-1] != '0)
		else $error("vector length below normalized range");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_done) |-> div_quot <= QUO_W'(ONE_Q14))
		else $error("tangent component above one");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQ |-> (!big && !tiny))
		else $error("magnitudes left normalization out of range");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> tan.valid)
		else $error("tangent word not presented");

endmodule

// ===== bench/tb_triangle_tangent_calc.sv =====
// Self-checking bench for triangle_tangent_calc: drives vertex words, predicts tangent words.
// Depends on tct_pkg, tct_if and the block's RTL.
module tb_triangle_tangent_calc;
	import tct_pkg::*;

	typedef struct packed {
		tan_t tx;
		tan_t ty;
		tan_t tz;
		logic deg;
		logic last;
	} tangent_word_t;

	logic clk;
	logic arst_n;

	tct_vtx_if vtx();
	tct_tan_if tan();

	triangle_tangent_calc DUT (
		.clk(clk),
		.arst_n(arst_n),
		.vtx(vtx),
		.tan(tan)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// Predictor state: two held vertices and the phase within the triangle.
	longint held_p[2][3];
	longint held_t[2][2];
	int corner_phase;

	tangent_word_t pending_tangents[$];
	int errors;
	int words_in;
	int words_out;
	int degenerate_seen;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_served;
	int hold_off;
	int stall_cycles;
	bit timed_out;

	// Integer square root, floor, bit by bit.
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Scale the vector to unit length in Q1.14; returns 1 for a zero vector.
	function automatic bit unit_scale(input longint c[3], output longint o[3]);
		longint unsigned a[3];
		longint unsigned m;
		longint unsigned sum;
		longint unsigned len;
		longint mag;
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = c[i] < 0 ? -c[i] : c[i];
			if (a[i] > m)
				m = a[i];
			o[i] = 0;
		end
		if (m == 0)
			return 1'b1;
		while (m >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++)
				a[i] >>= 1;
			m >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++)
				a[i] <<= 1;
			m <<= 1;
		end
		for (int i = 0; i < 3; i++)
			sum += a[i] * a[i];
		len = root_floor(sum);
		for (int i = 0; i < 3; i++) begin
			mag = (a[i] * ONE_Q14 + (len >> 1)) / len;
			o[i] = c[i] < 0 ? -mag : mag;
		end
		return 1'b0;
	endfunction

	// Advance the predictor by one vertex; on the third, queue three tangent words.
	task automatic predict_tangents(input pos_t px, pos_t py, pos_t pz, tex_t tu, tex_t tv);
		longint p[3][3];
		longint t[3][2];
		longint s1, t1, s2, t2, det, q1, q2;
		longint v[3];
		longint o[3];
		int a, b, c;
		bit deg;
		tangent_word_t w;
		p[2][0] = px;
		p[2][1] = py;
		p[2][2] = pz;
		t[2][0] = tu;
		t[2][1] = tv;
		if (corner_phase < 2) begin
			for (int k = 0; k < 3; k++)
				held_p[corner_phase][k] = p[2][k];
			held_t[corner_phase][0] = tu;
			held_t[corner_phase][1] = tv;
			corner_phase++;
			return;
		end
		for (int i = 0; i < 2; i++) begin
			for (int k = 0; k < 3; k++)
				p[i][k] = held_p[i][k];
			t[i][0] = held_t[i][0];
			t[i][1] = held_t[i][1];
		end
		for (int j = 0; j < ROT_COUNT; j++) begin
			a = j;
			b = (j + 1) % 3;
			c = (j + 2) % 3;
			s1 = t[b][0] - t[a][0];
			t1 = t[b][1] - t[a][1];
			s2 = t[c][0] - t[a][0];
			t2 = t[c][1] - t[a][1];
			det = s1 * t2 - s2 * t1;
			deg = 1'b1;
			for (int k = 0; k < 3; k++)
				o[k] = 0;
			if (det != 0) begin
				for (int k = 0; k < 3; k++) begin
					q1 = p[b][k] - p[a][k];
					q2 = p[c][k] - p[a][k];
					v[k] = t2 * q1 - t1 * q2;
					if (det < 0)
						v[k] = -v[k];
				end
				deg = unit_scale(v, o);
			end
			w.tx = tan_t'(o[0]);
			w.ty = tan_t'(o[1]);
			w.tz = tan_t'(o[2]);
			w.deg = deg;
			w.last = (j == ROT_COUNT - 1);
			pending_tangents.push_back(w);
		end
		corner_phase = 0;
	endtask

	// Offer one vertex word, idling first at the sender's rate; predict on acceptance.
	task automatic send_vertex(input pos_t px, pos_t py, pos_t pz, tex_t tu, tex_t tv);
		while ($urandom_range(99) < send_idle_pct) begin
			vtx.valid <= 1'b0;
			@(posedge clk);
		end
		vtx.valid <= 1'b1;
		vtx.pos_x <= px;
		vtx.pos_y <= py;
		vtx.pos_z <= pz;
		vtx.tex_u <= tu;
		vtx.tex_v <= tv;
		do
			@(posedge clk);
		while (!vtx.ready);
		predict_tangents(px, py, pz, tu, tv);
		words_in++;
	endtask

	task automatic send_triangle(input pos_t p[3][3], tex_t t[3][2]);
		for (int i = 0; i < 3; i++)
			send_vertex(p[i][0], p[i][1], p[i][2], t[i][0], t[i][1]);
	endtask

	function automatic pos_t rand_pos();
		case ($urandom_range(5))
			0: return pos_t'($urandom);
			1: return pos_t'($urandom_range(8191) - 4096);
			2: return $urandom_range(1) ? pos_t'(-(1 <<< (POS_W - 1)))
				: pos_t'((1 << (POS_W - 1)) - 1);
			default: return pos_t'($urandom) >>> $urandom_range(12);
		endcase
	endfunction

	function automatic tex_t rand_tex();
		case ($urandom_range(4))
			0: return tex_t'($urandom);
			1: return $urandom_range(1) ? tex_t'(16'sh8000) : tex_t'(16'sh7fff);
			2: return tex_t'($urandom_range(63) - 32);
			default: return tex_t'($urandom) >>> $urandom_range(8);
		endcase
	endfunction

	// Drop valid, wait until every predicted tangent word has come back, then settle.
	task automatic drain();
		vtx.valid <= 1'b0;
		while (pending_tangents.size() != 0 && !timed_out)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
	endtask

	// Directed: field extremes, zero determinant, zero vector, both determinant signs.
	task automatic test_directed();
		pos_t p[3][3];
		tex_t t[3][2];
		// Right triangle with positive determinant.
		p = '{'{0, 0, 0}, '{4096, 0, 0}, '{0, 4096, 0}};
		t = '{'{0, 0}, '{4096, 0}, '{0, 4096}};
		send_triangle(p, t);
		// Same, mirrored texture: negative determinant.
		t = '{'{0, 0}, '{0, 4096}, '{4096, 0}};
		send_triangle(p, t);
		// Collinear texcoords: zero determinant.
		t = '{'{100, 100}, '{200, 200}, '{300, 300}};
		send_triangle(p, t);
		// Coincident positions: zero vector.
		p = '{'{77, -5, 9}, '{77, -5, 9}, '{77, -5, 9}};
		t = '{'{0, 0}, '{4096, 0}, '{0, 4096}};
		send_triangle(p, t);
		// Full-scale positions and texcoords, all sign mixes.
		p = '{'{-(1 <<< 23), (1 << 23) - 1, -(1 <<< 23)},
			'{(1 << 23) - 1, -(1 <<< 23), (1 << 23) - 1},
			'{-1, 0, 1}};
		t = '{'{-32768, 32767}, '{32767, -32768}, '{-32768, -32768}};
		send_triangle(p, t);
		p = '{'{(1 << 23) - 1, (1 << 23) - 1, (1 << 23) - 1},
			'{-(1 <<< 23), -(1 <<< 23), -(1 <<< 23)}, '{0, 1, -1}};
		t = '{'{32767, 32767}, '{-32768, 0}, '{0, -32768}};
		send_triangle(p, t);
		// Tiny vectors that need a large left shift.
		p = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 0, 1}};
		t = '{'{0, 0}, '{1, 0}, '{0, 1}};
		send_triangle(p, t);
		drain();
	endtask

	// Random: mostly random triangles, a few with forced degenerate texcoords or coincident positions.
	task automatic test_random(input int n_tris);
		pos_t p[3][3];
		tex_t t[3][2];
		for (int n = 0; n < n_tris; n++) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++)
					p[i][k] = rand_pos();
				t[i][0] = rand_tex();
				t[i][1] = rand_tex();
			end
			if ($urandom_range(9) == 0)
				t[2] = t[1];
			if ($urandom_range(14) == 0)
				p[1] = p[0];
			send_triangle(p, t);
		end
	endtask

	// Hold the receiver off while vertices keep coming so the block backs up.
	task automatic test_backpressure();
		hold_requests++;
		test_random(4);
		drain();
	endtask

	// Receiver: random stalls at its rate, plus a long hold-off counted here.
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_off <= 1500;
			tan.ready <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			tan.ready <= 0;
		end else begin
			tan.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each accepted tangent word with the oldest prediction.
	always @(posedge clk) begin
		tangent_word_t got;
		tangent_word_t want;
		if (arst_n && tan.valid && tan.ready) begin
			got = '{tan.tan_x, tan.tan_y, tan.tan_z, tan.degenerate, tan.last_of_triangle};
			words_out++;
			if (got.deg)
				degenerate_seen++;
			if (pending_tangents.size() == 0) begin
				errors++;
				$display("%0t: unexpected tangent word %p", $time, got);
			end else begin
				want = pending_tangents.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: tangent mismatch expected %p actual %p", $time, want, got);
				end
			end
		end
	end

	// Watchdog: count cycles with no accepted word on either side.
	always @(posedge clk) begin
		if ((vtx.valid && vtx.ready) || (tan.valid && tan.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 20000) begin
			timed_out = 1'b1;
			$display("%0t: timeout, %0d tangent words outstanding", $time,
				pending_tangents.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		vtx.valid = 0;
		vtx.pos_x = 0;
		vtx.pos_y = 0;
		vtx.pos_z = 0;
		vtx.tex_u = 0;
		vtx.tex_v = 0;
		corner_phase = 0;
		words_in = 0;
		hold_requests = 0;
		send_idle_pct = 31;
		recv_idle_pct = 65;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();

		test_random(25);
		drain();
		test_backpressure();

		send_idle_pct = 65;
		recv_idle_pct = 31;
		test_random(25);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(20);
		drain();

		$display("Sent %0d vertex words, checked %0d tangent words (%0d degenerate).",
			words_in, words_out, degenerate_seen);
		$display("Covered field extremes, both determinant signs, degenerate cases, stalls.");
		if (errors == 0 && pending_tangents.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
